FILE: hw/rtl/lrupr_pkg.sv
package lrupr_pkg;

    // Fixed field widths
    localparam int PAGE_W  = 4;
    localparam int FRAME_W = 4;
    localparam int COUNT_W = 4;

    // Frame count after reset
    localparam logic [FRAME_W-1:0] FRAMES_RESET = 4'd4;

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [FRAME_W-1:0] frames_t;
    typedef logic [COUNT_W-1:0] count_t;

    // One result transaction
    typedef struct packed {
        logic   hit;
        logic   evicted;
        page_t  evicted_page;
        count_t resident_count;
    } result_t;

endpackage

FILE: hw/rtl/lrupr_req_if.sv
interface lrupr_req_if;
    logic           valid;
    logic           ready;
    lrupr_pkg::page_t page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

FILE: hw/rtl/lrupr_rsp_if.sv
interface lrupr_rsp_if;
    logic              valid;
    logic              ready;
    logic              hit;
    logic              evicted;
    lrupr_pkg::page_t  evicted_page;
    lrupr_pkg::count_t resident_count;

    modport source (output valid, output hit, output evicted, output evicted_page,
                    output resident_count, input ready);
    modport sink   (input valid, input hit, input evicted, input evicted_page,
                    input resident_count, output ready);
endinterface

FILE: hw/rtl/lrupr_cfg_if.sv
interface lrupr_cfg_if;
    logic               valid;
    logic               ready;
    lrupr_pkg::frames_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/lru_page_replacement.sv
// LRU page replacement over up to MAX_FRAMES page frames. Each req transaction
// carries one page reference; each produces exactly one rsp transaction with
// hit, evicted, evicted_page (0 when nothing was evicted) and the resident
// count after the reference. The block sustains one reference per clock while
// rsp.ready is high; a reference passes the input register, then the result
// register, and the list compare-and-shift across all frames is combinational
// between them. The frame count (cfg, reset value 4) clamps to 1..MAX_FRAMES
// and should be written only while no reference is in flight; lowering it
// below the current occupancy drops nothing at once, later misses replace
// the least recent page. No clearing pass is needed after reset.
module lru_page_replacement
#(
    parameter int MAX_FRAMES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    lrupr_req_if.sink   req,
    lrupr_rsp_if.source rsp,
    lrupr_cfg_if.sink   cfg
);

    lrupr_pkg::frames_t frames_reg;
    lrupr_pkg::page_t   page;
    lrupr_pkg::result_t result;
    logic               pending;
    logic               can_load;
    logic               advance;

    // Frame count register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= lrupr_pkg::FRAMES_RESET;
        end
        else if (cfg.valid)
        begin
            frames_reg <= cfg.data;
        end
    end

    // A held reference moves on when the result slot can take it
    assign advance = pending && can_load;

    lrupr_in_reg u_in_reg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .page    (page),
        .pending (pending)
    );

    lrupr_list
    #(
        .MAX_FRAMES (MAX_FRAMES)
    )
    u_list
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .page          (page),
        .frames_in_use (frames_reg),
        .result        (result)
    );

    lrupr_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .rsp      (rsp)
    );

endmodule

FILE: hw/rtl/lrupr_in_reg.sv
module lrupr_in_reg
(
    input  logic             clk,
    input  logic             rst_n,
    lrupr_req_if.sink        req,
    input  logic             advance,
    output lrupr_pkg::page_t page,
    output logic             pending
);

    logic             pending_reg;
    logic             pending_next;
    lrupr_pkg::page_t page_reg;
    logic             load;

    // Take a new reference when empty or when the held one moves on
    assign req.ready    = !pending_reg || advance;
    assign load         = req.valid && req.ready;
    assign pending_next = load || (pending_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            page_reg <= req.page;
        end
    end

    assign page    = page_reg;
    assign pending = pending_reg;

endmodule

FILE: hw/rtl/lrupr_list.sv
module lrupr_list
#(
    parameter int MAX_FRAMES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  lrupr_pkg::page_t     page,
    input  lrupr_pkg::frames_t   frames_in_use,
    output lrupr_pkg::result_t   result
);

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    // Recency list, entry 0 most recent; entries are read only once written
    lrupr_pkg::page_t list_reg  [MAX_FRAMES];
    lrupr_pkg::page_t list_next [MAX_FRAMES];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    logic [MAX_FRAMES-1:0] match;
    logic                  hit;
    logic [IW-1:0]         pos;
    logic [CW-1:0]         cap;
    logic                  full;
    logic [CW-1:0]         limit;
    logic [CW-1:0]         last;
    logic [IW-1:0]         last_idx;
    lrupr_pkg::page_t      ev_page;
    logic [31:0]           count_wide;

    // Effective capacity: 0 acts as 1, clamp to MAX_FRAMES
    always_comb
    begin
        if (frames_in_use == '0)
        begin
            cap = CW'(1);
        end
        else if (32'(frames_in_use) > 32'(MAX_FRAMES))
        begin
            cap = CW'(MAX_FRAMES);
        end
        else
        begin
            cap = CW'(frames_in_use);
        end
    end

    // Parallel compare against valid entries, first match wins
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            match[i] = (32'(i) < 32'(count_reg)) && (list_reg[i] == page);
        end
        hit = |match;
        pos = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                pos = IW'(i);
            end
        end
    end

    // Miss handling: evict the tail when all frames are taken
    assign full     = (count_reg >= cap);
    assign last     = count_reg - CW'(1);
    assign last_idx = last[IW-1:0];
    assign ev_page  = (!hit && full) ? list_reg[last_idx] : '0;

    always_comb
    begin
        if (hit)
        begin
            limit = CW'(pos);
        end
        else if (full)
        begin
            limit = last;
        end
        else
        begin
            limit = count_reg;
        end
    end

    assign count_next = (!hit && !full) ? count_reg + CW'(1) : count_reg;

    // Shift entries 1..limit toward the tail, new page at the front
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (i == 0)
            begin
                list_next[i] = page;
            end
            else if (32'(i) <= 32'(limit))
            begin
                list_next[i] = list_reg[i-1];
            end
            else
            begin
                list_next[i] = list_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                list_reg[i] <= list_next[i];
            end
        end
    end

    // Result for this reference
    assign count_wide            = 32'(count_next);
    assign result.hit            = hit;
    assign result.evicted        = !hit && full;
    assign result.evicted_page   = ev_page;
    assign result.resident_count = count_wide[lrupr_pkg::COUNT_W-1:0];

endmodule

FILE: hw/rtl/lrupr_out_reg.sv
module lrupr_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  lrupr_pkg::result_t result,
    output logic               can_load,
    lrupr_rsp_if.source        rsp
);

    logic               valid_reg;
    logic               valid_next;
    lrupr_pkg::result_t result_reg;

    // Slot frees up when empty or when the held result is taken
    assign can_load   = !valid_reg || rsp.ready;
    assign valid_next = load || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.hit            = result_reg.hit;
    assign rsp.evicted        = result_reg.evicted;
    assign rsp.evicted_page   = result_reg.evicted_page;
    assign rsp.resident_count = result_reg.resident_count;

endmodule

FILE: tb/lrupr_checker.sv
`timescale 1ns / 100ps

module lrupr_checker
(
    input  logic  clk,
    input  logic  rst_n,
    lrupr_req_if  req,
    lrupr_rsp_if  rsp,
    lrupr_cfg_if  cfg,
    output int    mismatches,
    output int    outstanding
);

    localparam int FRAMES_MAX = 8;

    // Shadow copy of the cache state
    lrupr_pkg::frames_t frames_cfg;
    lrupr_pkg::page_t   recency [FRAMES_MAX];
    int unsigned        occupancy;

    // Results still owed by the block, oldest first
    lrupr_pkg::result_t owed_results [$];
    lrupr_pkg::result_t seen;
    lrupr_pkg::result_t wanted;

    // Apply one page reference to the shadow list and return its result
    function automatic lrupr_pkg::result_t reference_page(lrupr_pkg::page_t pg);
        int unsigned        cap;
        int unsigned        cnt;
        int unsigned        pos;
        int unsigned        i;
        bit                 found;
        lrupr_pkg::result_t r;
        if (frames_cfg == 0)
            cap = 1;
        else if (frames_cfg > FRAMES_MAX)
            cap = FRAMES_MAX;
        else
            cap = frames_cfg;
        cnt = (occupancy > FRAMES_MAX) ? FRAMES_MAX : occupancy;
        pos = 0;
        found = 1'b0;
        r = '0;
        for (i = 0; i < cnt; i++)
        begin
            if (!found && recency[i] == pg)
            begin
                found = 1'b1;
                pos = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
        end
        else if (cnt >= cap && cnt > 0)
        begin
            // all frames taken: the tail page goes out
            r.evicted = 1'b1;
            r.evicted_page = recency[cnt-1];
            pos = cnt - 1;
        end
        else
        begin
            pos = cnt;
            cnt++;
        end
        if (pos >= FRAMES_MAX)
            pos = FRAMES_MAX - 1;
        // shift the head down and put the page in front
        for (i = pos; i > 0; i--)
            recency[i] = recency[i-1];
        recency[0] = pg;
        occupancy = cnt;
        r.resident_count = lrupr_pkg::count_t'(cnt);
        return r;
    endfunction

    // Watch the three channels, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg = lrupr_pkg::FRAMES_RESET;
            occupancy = 0;
            owed_results.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                frames_cfg = cfg.data;

            if (rsp.valid && rsp.ready)
            begin
                seen.hit = rsp.hit;
                seen.evicted = rsp.evicted;
                seen.evicted_page = rsp.evicted_page;
                seen.resident_count = rsp.resident_count;
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction,", $time,
                             " actual hit/ev/page/count %0d/%0d/%0d/%0d",
                             seen.hit, seen.evicted, seen.evicted_page,
                             seen.resident_count);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    wanted = owed_results.pop_front();
                    if (seen !== wanted)
                    begin
                        $display("%0t: result mismatch hit/ev/page/count,", $time,
                                 " expected %0d/%0d/%0d/%0d,",
                                 wanted.hit, wanted.evicted, wanted.evicted_page,
                                 wanted.resident_count,
                                 " actual %0d/%0d/%0d/%0d",
                                 seen.hit, seen.evicted, seen.evicted_page,
                                 seen.resident_count);
                        mismatches = mismatches + 1;
                    end
                end
            end

            if (req.valid && req.ready)
                owed_results.push_back(reference_page(req.page));

            outstanding <= owed_results.size();
        end
    end

endmodule

FILE: tb/tb_lru_page_replacement.sv
`timescale 1ns / 100ps

module tb_lru_page_replacement;

    localparam int IDLE_LIMIT     = 500;
    localparam int DRAIN_CYCLES   = 4;
    localparam int ITEMS_PER_PASS = 94;
    localparam int MAX_GAP        = 12;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   idle_cycles;

    // Random traffic shaping
    bit          tx_burst;
    bit          rx_burst;
    int unsigned ws_base;
    int unsigned ws_span;

    lrupr_req_if req_if ();
    lrupr_rsp_if rsp_if ();
    lrupr_cfg_if cfg_if ();

    lru_page_replacement i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    lrupr_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg         (cfg_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one page reference, keep valid high if the next one follows at once
    task automatic send_page(input lrupr_pkg::page_t pg);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.page  <= pg;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // Stop offering and wait until every owed result has come back
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Frame count write, only with nothing in flight
    task automatic set_frames(input lrupr_pkg::frames_t frames);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= frames;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly references inside a small working set, some scattered ones
    function automatic lrupr_pkg::page_t draw_page();
        if ($urandom_range(0, 29) == 0)
            ws_base = (ws_base + 1) % 16;
        if ($urandom_range(0, 99) < 15)
            return lrupr_pkg::page_t'($urandom_range(0, 15));
        return lrupr_pkg::page_t'((ws_base + $urandom_range(0, ws_span - 1)) % 16);
    endfunction

    // Result side: random stalls with stretches of none
    initial
    begin
        int stall;
        rsp_if.ready <= 1'b0;
        rx_burst = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
        end
    end

    // Watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_lru_page_replacement NOT OK");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        lrupr_pkg::page_t   warm_up [];
        lrupr_pkg::page_t   shrunk [];
        lrupr_pkg::page_t   grown [];
        lrupr_pkg::page_t   single [];
        lrupr_pkg::page_t   clamped [];
        lrupr_pkg::frames_t pass_frames [];
        warm_up      = '{0, 15, 0, 1, 2, 15, 3, 4, 0};
        shrunk       = '{9, 4, 9, 10};
        grown        = '{11, 12, 13, 14, 5, 13};
        single       = '{6, 6, 13};
        clamped      = '{7, 8};
        pass_frames  = '{1, 8, 15, 0, 3, 6, 2, 5, 7, 4, 9, 0};
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.page  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        idle_cycles  = 0;
        tx_burst     = 1'b0;
        ws_base      = 0;
        ws_span      = 4;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame count: fill, hit, evict
        foreach (warm_up[i])
            send_page(warm_up[i]);
        // frame count below occupancy: misses replace the tail, count holds
        set_frames(2);
        foreach (shrunk[i])
            send_page(shrunk[i]);
        // full width: grow to all frames, deep hit
        set_frames(8);
        foreach (grown[i])
            send_page(grown[i]);
        // zero acts as one frame
        set_frames(0);
        foreach (single[i])
            send_page(single[i]);
        // above the maximum acts as the maximum
        set_frames(15);
        foreach (clamped[i])
            send_page(clamped[i]);

        // random passes, last one with a random frame count
        pass_frames[pass_frames.size()-1] = lrupr_pkg::frames_t'($urandom_range(0, 15));
        foreach (pass_frames[p])
        begin
            set_frames(pass_frames[p]);
            ws_base = $urandom_range(0, 15);
            ws_span = $urandom_range(1, 10);
            repeat (ITEMS_PER_PASS)
                send_page(draw_page());
        end

        wait_idle();
        if (mismatches == 0)
            $display("tb_lru_page_replacement OK");
        else
            $display("tb_lru_page_replacement NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_req_if.sv
hw/rtl/lrupr_rsp_if.sv
hw/rtl/lrupr_cfg_if.sv
hw/rtl/lrupr_in_reg.sv
hw/rtl/lrupr_list.sv
hw/rtl/lrupr_out_reg.sv
hw/rtl/lru_page_replacement.sv
tb/lrupr_checker.sv
tb/tb_lru_page_replacement.sv
